// ===== rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types, codes and defaults of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // defaults for the top-level parameters
    localparam int POOL_BLOCKS_DEF = 1024;
    localparam int ADDR_BITS_DEF   = 32;

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int LOG2_W  = 5;
    localparam int CFGCNT_W = 11;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int REGIDX_W = 2;

    // block size limits (log2 of bytes)
    localparam logic [LOG2_W-1:0] LOG2_MIN = 5'd4;
    localparam logic [LOG2_W-1:0] LOG2_MAX = 5'd16;

    // register reset values
    localparam logic [DATA_W-1:0]   BASE_RST  = 32'd0;
    localparam logic [LOG2_W-1:0]   LOG2_RST  = 5'd4;
    localparam logic [CFGCNT_W-1:0] COUNT_RST = 11'd1024;

    // configuration register indexes
    localparam logic [REGIDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_LOG2  = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_COUNT = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_INIT    = 2'd2,
        FN_DESTROY = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_INACTIVE   = 3'd2,
        ST_RANGE      = 3'd3,
        ST_MISALIGNED = 3'd4
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // input beat taken, run first stage
        logic walk;     // write one link of the init walk
        logic commit;   // finish the item, load the output register
    } cmd_t;

endpackage : fbpa_pkg
`default_nettype wire

// ===== rtl/fbpa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_datapath
// config registers, pool state, next-link memory and the two-step alloc/free
// ----------------------------------------------------------------------------
module fbpa_datapath
    import fbpa_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [REGIDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]   cfg_data,
    input  wire logic [FUNC_W-1:0]   in_func,
    input  wire logic [DATA_W-1:0]   in_addr,
    input  wire cmd_t                cmd,
    output logic                     walk_last,
    output logic [DATA_W-1:0]        out_data,
    output logic [STAT_W-1:0]        out_status
);

    localparam int IDX_W  = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(POOL_BLOCKS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_BLOCKS);

    // configuration registers
    logic [DATA_W-1:0]   base_reg;
    logic [LOG2_W-1:0]   log2_reg;
    logic [CFGCNT_W-1:0] count_reg;

    // pool state
    logic [LINK_W-1:0]    head_reg, head_next;
    logic                 active_reg, active_next;
    logic [ADDR_BITS-1:0] pool_base_reg;
    logic [LOG2_W-1:0]    pool_log2_reg;
    logic [CNT_W-1:0]     pool_count_reg;
    logic [IDX_W-1:0]     walk_reg;

    // first-stage registers
    func_t                func_reg;
    logic [ADDR_BITS-1:0] off_reg;
    logic                 below_reg;
    logic [ADDR_BITS-1:0] grant_reg;
    logic [LINK_W-1:0]    rd_link_reg;

    // output register
    logic [DATA_W-1:0]    out_data_reg;
    status_t              out_status_reg;

    // link memory
    logic [LINK_W-1:0] link_mem [0:POOL_BLOCKS-1];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [LINK_W-1:0] mem_wd;

    // clamped config for init
    logic [LOG2_W-1:0]    log2_cl;
    logic [CNT_W-1:0]     count_cl;
    logic [63:0]          base_mask64;
    logic [ADDR_BITS-1:0] base_al;

    always_comb
    begin
        if (log2_reg < LOG2_MIN)
            log2_cl = LOG2_MIN;
        else if (log2_reg > LOG2_MAX)
            log2_cl = LOG2_MAX;
        else
            log2_cl = log2_reg;

        if (count_reg == '0)
            count_cl = CNT_W'(1);
        else if (32'(count_reg) > 32'(POOL_BLOCKS))
            count_cl = CNT_W'(POOL_BLOCKS);
        else
            count_cl = CNT_W'(count_reg);

        base_mask64 = 64'(base_reg) & ~((64'd1 << log2_cl) - 64'd1);
        base_al     = base_mask64[ADDR_BITS-1:0];
    end

    // first stage: offset of freed address and address of the head block
    logic [63:0]          addr64;
    logic [ADDR_BITS-1:0] addr_a;
    logic [63:0]          head_shift;
    logic [IDX_W-1:0]     head_idx;

    always_comb
    begin
        addr64     = 64'(in_addr);
        addr_a     = addr64[ADDR_BITS-1:0];
        head_idx   = head_reg[IDX_W-1:0];
        head_shift = 64'(head_idx) << pool_log2_reg;
    end

    // second stage: decide status and next pool state
    logic [63:0]       off64;
    logic [63:0]       span64;
    logic [63:0]       lsb_mask64;
    logic [63:0]       blk64;
    logic [63:0]       grant64;
    logic [IDX_W-1:0]  free_blk;
    logic              push;
    status_t           status_c;
    logic [DATA_W-1:0] grant_c;

    always_comb
    begin
        off64      = 64'(off_reg);
        span64     = 64'(pool_count_reg) << pool_log2_reg;
        lsb_mask64 = (64'd1 << pool_log2_reg) - 64'd1;
        blk64      = off64 >> pool_log2_reg;
        free_blk   = blk64[IDX_W-1:0];
        grant64    = 64'(grant_reg);
        status_c   = ST_OK;
        grant_c    = '0;
        head_next  = head_reg;
        active_next = active_reg;
        push       = 1'b0;
        case (func_reg)
            FN_INIT:
            begin
                head_next   = '0;
                active_next = 1'b1;
            end
            FN_DESTROY:
            begin
                if (!active_reg)
                    status_c = ST_INACTIVE;
                else
                begin
                    active_next = 1'b0;
                    head_next   = NULL_LINK;
                end
            end
            FN_ALLOC:
            begin
                if (!active_reg)
                    status_c = ST_INACTIVE;
                else if (head_reg >= NULL_LINK)
                    status_c = ST_EMPTY;
                else
                begin
                    grant_c   = grant64[DATA_W-1:0];
                    head_next = rd_link_reg;
                end
            end
            default:
            begin
                // free
                if (!active_reg)
                    status_c = ST_INACTIVE;
                else if (below_reg || off64 >= span64)
                    status_c = ST_RANGE;
                else if ((off64 & lsb_mask64) != 64'd0)
                    status_c = ST_MISALIGNED;
                else
                begin
                    push      = 1'b1;
                    head_next = LINK_W'(free_blk);
                end
            end
        endcase
    end

    // init walk link and end of walk
    logic [CNT_W-1:0] walk_inc;

    always_comb
    begin
        walk_inc  = CNT_W'(walk_reg) + CNT_W'(1);
        walk_last = (walk_inc == pool_count_reg);
    end

    // one write port: init walk or free push
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = walk_reg;
        mem_wd = walk_last ? NULL_LINK : LINK_W'(walk_inc);
        if (cmd.walk)
            mem_we = 1'b1;
        else if (cmd.commit && push)
        begin
            mem_we = 1'b1;
            mem_wa = free_blk;
            mem_wd = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_wa] <= mem_wd;
        if (cmd.accept)
            rd_link_reg <= link_mem[head_idx];
    end

    // control state: registers, pool state, walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= BASE_RST;
            log2_reg       <= LOG2_RST;
            count_reg      <= COUNT_RST;
            head_reg       <= NULL_LINK;
            active_reg     <= 1'b0;
            pool_base_reg  <= '0;
            pool_log2_reg  <= LOG2_RST;
            pool_count_reg <= CNT_W'(POOL_BLOCKS);
            walk_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE:  base_reg  <= cfg_data;
                    REG_LOG2:  log2_reg  <= cfg_data[LOG2_W-1:0];
                    REG_COUNT: count_reg <= cfg_data[CFGCNT_W-1:0];
                    default:   ;
                endcase
            end
            if (cmd.accept && func_t'(in_func) == FN_INIT)
            begin
                pool_base_reg  <= base_al;
                pool_log2_reg  <= log2_cl;
                pool_count_reg <= count_cl;
                walk_reg       <= '0;
            end
            else if (cmd.walk)
                walk_reg <= walk_inc[IDX_W-1:0];
            if (cmd.commit)
            begin
                head_reg   <= head_next;
                active_reg <= active_next;
            end
        end
    end

    // first-stage and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= func_t'(in_func);
            off_reg   <= addr_a - pool_base_reg;
            below_reg <= (addr_a < pool_base_reg);
            grant_reg <= pool_base_reg + head_shift[ADDR_BITS-1:0];
        end
        if (cmd.commit)
        begin
            out_data_reg   <= grant_c;
            out_status_reg <= status_c;
        end
    end

    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule : fbpa_datapath
`default_nettype wire

// ===== rtl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ctrl
// controller: input handshake, init walk sequencing and output valid
// ----------------------------------------------------------------------------
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [FUNC_W-1:0] in_func,
    input  wire logic              out_ready,
    input  wire logic              walk_last,
    output logic                   in_ready,
    output logic                   out_valid,
    output cmd_t                   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    // commands from current state
    always_comb
    begin
        out_free   = !valid_reg || out_ready;
        cmd.accept = in_valid && ready_reg;
        cmd.walk   = (state_reg == S_WALK);
        cmd.commit = (state_reg == S_EXEC) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    ready_next = 1'b0;
                    if (func_t'(in_func) == FN_INIT)
                        state_next = S_WALK;
                    else
                        state_next = S_EXEC;
                end
            end
            S_WALK:
            begin
                if (walk_last)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ready_reg;
    assign out_valid = valid_reg;

endmodule : fbpa_ctrl
`default_nettype wire

// ===== rtl/fixed_block_pool_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Alloc, free and destroy: the input beat is registered in the first stage, then the item commits in S_EXEC.
// One alloc, free or destroy in flight at a time; the next is taken once the result beat is loaded.
// Init walks the link memory one entry per cycle
// through its single write port, then the result beat is issued.
// Reset (rst_n low, asynchronous): pool inactive, free list empty, registers at defaults;
// the link memory is not cleared and is written by init.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// fixed-size block allocator with a LIFO free list over a next-link memory
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write port
    input  wire logic                cfg_we,
    input  wire logic [REGIDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]   cfg_data,
    // request stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [DATA_W-1:0]   s_tdata,   // [31:0] block_address
    input  wire logic [FUNC_W-1:0]   s_tuser,   // [1:0] func
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [DATA_W-1:0]        m_tdata,   // [31:0] granted_address
    output logic [STAT_W-1:0]        m_tuser    // [2:0] status
);

    cmd_t cmd;
    logic walk_last;

    // controller
    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .out_ready (m_tready),
        .walk_last (walk_last),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    // datapath
    fbpa_datapath #(
        .POOL_BLOCKS (POOL_BLOCKS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_func    (s_tuser),
        .in_addr    (s_tdata),
        .cmd        (cmd),
        .walk_last  (walk_last),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule : fixed_block_pool_allocator_core
`default_nettype wire

// ===== rtl/fbpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_checker
// port-level checks of the allocator core, bound to the top level
// ----------------------------------------------------------------------------
module fbpa_checker
    import fbpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [DATA_W-1:0] m_tdata,
    input  wire logic [STAT_W-1:0] m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // only successful results carry an address
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("failed result carries a nonzero address");

    // one item in flight: ready drops after an accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // a new result appears only while the input side is busy
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result beat without an item in flight");

endmodule : fbpa_checker

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
